### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int VALUE_W          = 32;
    localparam int PRIO_W           = 8;
    localparam int OCC_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // Input word layout: value, then priority.
    localparam int S_DATA_W = 40;
    // Output word layout: value, priority, occupancy, zero pad.
    localparam int M_DATA_W = 48;

    typedef enum logic
    {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // One stored entry.
    typedef struct packed
    {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed
    {
        logic   enq;
        logic   deq;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded min-first priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ channel. s_tuser selects the operation
//   (0 enqueue, 1 dequeue); s_tdata carries the value and its priority.
//   Every input word produces exactly one output word on the m_ channel:
//   a status in m_tuser, and in m_tdata the removed value and priority
//   (zero unless a dequeue succeeded) and the occupancy after the step.
//   Equal priorities leave in arrival order.
// Timing:
//   m_tvalid rises the cycle after acceptance. Unless stalled, one word is
//   accepted per cycle: every cell compares with the new priority and loads
//   from itself or a neighbor in the same cycle, so the chain sets the rate.
//   s_tready is high while the output register is empty or being drained.
// Reset:
//   rst_n clears the entry count and the output valid flag; the queue is
//   empty afterwards. Cell contents are not cleared.
// Stall:
//   While m_tready is low with a word pending, s_tready drops and the
//   pending output word holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] value, [39:32] priority_req
    input  wire logic [spq_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] kind
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] out_value, [39:32] out_priority, [44:40] occupancy, [47:45] zero
    output logic [spq_pkg::M_DATA_W-1:0]       m_tdata,
    // [1:0] status
    output logic [1:0]                         m_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = spq_pkg::M_DATA_W - spq_pkg::VALUE_W - spq_pkg::PRIO_W
                           - spq_pkg::OCC_W;

    logic                accept;
    logic                is_deq;
    logic                full;
    logic                empty;
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     cell_entry [CAPACITY];
    logic                cell_stay  [CAPACITY];

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic [CNT_W+spq_pkg::OCC_W-1:0]  occ_wide;

    spq_pkg::status_t                 status;
    logic [spq_pkg::VALUE_W-1:0]      res_value;
    logic [spq_pkg::PRIO_W-1:0]       res_prio;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [spq_pkg::M_DATA_W-1:0]     out_data_reg;
    logic [1:0]                       out_user_reg;

    // Handshake and queue condition.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_deq   = (s_tuser == spq_pkg::KIND_DEQ);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // Operation broadcast to the chain.
    assign ctrl.enq             = accept && !is_deq && !full;
    assign ctrl.deq             = accept && is_deq && !empty;
    assign ctrl.new_entry.value = s_tdata[spq_pkg::VALUE_W-1:0];
    assign ctrl.new_entry.prio  = s_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];

    // Chain of cells, cell 0 at the front.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;
        logic            left_stay;

        if (i == 0)
        begin : g_front
            assign left_entry = ctrl.new_entry;
            assign left_stay  = 1'b1;
        end
        else
        begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign left_stay  = cell_stay[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        spq_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_entry  (left_entry),
            .left_stay   (left_stay),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
        );
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

    // Result word for the accepted input word.
    always_comb
    begin
        status    = spq_pkg::STATUS_OK;
        res_value = '0;
        res_prio  = '0;
        if (is_deq)
        begin
            if (empty)
            begin
                status = spq_pkg::STATUS_UNDERFLOW;
            end
            else
            begin
                res_value = cell_entry[0].value;
                res_prio  = cell_entry[0].prio;
            end
        end
        else if (full)
        begin
            status = spq_pkg::STATUS_OVERFLOW;
        end
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_tready)
        begin
            out_valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, occ_wide[spq_pkg::OCC_W-1:0], res_prio, res_value};
            out_user_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

### src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic                clk,
    input  wire spq_pkg::cell_ctrl_t ctrl,
    input  wire logic [CNT_W-1:0]    count,
    input  wire spq_pkg::entry_t     left_entry,
    input  wire logic                left_stay,
    input  wire spq_pkg::entry_t     right_entry,
    output spq_pkg::entry_t          entry,
    output logic                     stay
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;
    logic            occupied;

    // An occupied entry with a priority number not above the new one stays put,
    // which keeps equal priorities in arrival order.
    assign occupied = (count > IDX);
    assign stay     = occupied && (entry_reg.prio <= ctrl.new_entry.prio);
    assign entry    = entry_reg;

    // Keep, take the new entry, take the left neighbor, or take the right one.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (!stay)
            begin
                entry_next = left_stay ? ctrl.new_entry : left_entry;
            end
        end
        else if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module spq_checker #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [spq_pkg::S_DATA_W-1:0]  s_tdata,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [spq_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic [1:0]                    m_tuser
);

    localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(CAPACITY);

    logic                          ovf_word;
    logic                          unf_word;
    logic [spq_pkg::VALUE_W-1:0]   m_value;
    logic [spq_pkg::PRIO_W-1:0]    m_prio;
    logic [spq_pkg::OCC_W-1:0]     m_occ;
    logic                          unused_in;

    assign ovf_word  = m_tvalid && (m_tuser == spq_pkg::STATUS_OVERFLOW);
    assign unf_word  = m_tvalid && (m_tuser == spq_pkg::STATUS_UNDERFLOW);
    assign m_value   = m_tdata[spq_pkg::VALUE_W-1:0];
    assign m_prio    = m_tdata[spq_pkg::VALUE_W +: spq_pkg::PRIO_W];
    assign m_occ     = m_tdata[spq_pkg::VALUE_W + spq_pkg::PRIO_W +: spq_pkg::OCC_W];
    assign unused_in = s_tvalid ^ (^s_tdata) ^ s_tuser;

    // A stalled output word holds.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // An empty output register never blocks the input.
    `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)

    // Overflow only on a full queue, with no data returned.
    `ASSERT_IMPL(a_overflow_word, clk, rst_n, ovf_word, m_occ == FULL_OCC && m_value == '0)

    // Underflow only on an empty queue, with no data returned.
    `ASSERT_IMPL(a_underflow_word, clk, rst_n, unf_word,
                 m_occ == '0 && m_value == '0 && m_prio == '0 && unused_in == unused_in)

endmodule

bind stable_priority_queue spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/stable_priority_queue_tb.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_tb
// Self-checking testbench for the bounded min-first priority queue.
// ----------------------------------------------------------------------------
// A short directed table covers the empty dequeue, the extremes of value and
// priority, ties, filling to capacity and overflow. Random words
// follow. Enqueue-heavy and dequeue-heavy stretches take the occupancy across
// its whole range. Every accepted input word runs through a local sorted-slot
// predictor. Every output word is compared field by field with the oldest
// prediction. The runs go through several idling patterns on both sides, and
// once through a long output hold-off that backs the queue up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_priority_queue_tb;

    localparam int CAPACITY        = 16;
    localparam int RAND_PER_PHASE  = 225;
    localparam int HOLD_CYCLES     = 80;
    localparam int MAX_GAP         = 60;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;

    // One output word as the predictor sees it.
    typedef struct packed
    {
        spq_pkg::status_t            status;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]  prio;
        logic [spq_pkg::OCC_W-1:0]   occ;
    } result_t;

    // One row of the directed table. The expected fields count only when
    // typed is set; other rows go to the predictor.
    typedef struct packed
    {
        spq_pkg::kind_t              op;
        logic [spq_pkg::VALUE_W-1:0] val;
        logic [spq_pkg::PRIO_W-1:0]  pri;
        logic [4:0]                  reps;
        logic                        typed;
        spq_pkg::status_t            exp_status;
        logic [spq_pkg::VALUE_W-1:0] exp_value;
        logic [spq_pkg::PRIO_W-1:0]  exp_prio;
        logic [spq_pkg::OCC_W-1:0]   exp_occ;
    } dir_row_t;

    localparam int DIR_ROWS = 8;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Dequeue right after reset.
        '{spq_pkg::KIND_DEQ, 32'h0000_0000, 8'h00, 5'd1,  1'b1, spq_pkg::STATUS_UNDERFLOW,
          32'h0000_0000, 8'h00, 5'd0},
        // Value and priority extremes, with a tie at the lowest priority.
        '{spq_pkg::KIND_ENQ, 32'h7FFF_FFFF, 8'hFF, 5'd1,  1'b1, spq_pkg::STATUS_OK,
          32'h0000_0000, 8'h00, 5'd1},
        '{spq_pkg::KIND_ENQ, 32'h8000_0000, 8'h00, 5'd1,  1'b1, spq_pkg::STATUS_OK,
          32'h0000_0000, 8'h00, 5'd2},
        '{spq_pkg::KIND_ENQ, 32'hFFFF_FFFF, 8'hFF, 5'd1,  1'b1, spq_pkg::STATUS_OK,
          32'h0000_0000, 8'h00, 5'd3},
        '{spq_pkg::KIND_ENQ, 32'h0000_0000, 8'h80, 5'd1,  1'b1, spq_pkg::STATUS_OK,
          32'h0000_0000, 8'h00, 5'd4},
        // Dequeue with junk in the data fields, which must be ignored.
        '{spq_pkg::KIND_DEQ, 32'hAAAA_AAAA, 8'h37, 5'd1,  1'b1, spq_pkg::STATUS_OK,
          32'h8000_0000, 8'h00, 5'd3},
        // Fill to capacity with one shared priority, values counting up.
        '{spq_pkg::KIND_ENQ, 32'h0000_0100, 8'h07, 5'd13, 1'b0, spq_pkg::STATUS_OK,
          32'h0000_0000, 8'h00, 5'd0},
        // Enqueue into the full queue.
        '{spq_pkg::KIND_ENQ, 32'h1234_5678, 8'h00, 5'd1,  1'b1, spq_pkg::STATUS_OVERFLOW,
          32'h0000_0000, 8'h00, 5'd16}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [spq_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [spq_pkg::M_DATA_W-1:0]   m_tdata;
    logic [1:0]                     m_tuser;

    // Predictor state: sorted slots, slot 0 at the front.
    logic [spq_pkg::VALUE_W-1:0]    slot_val [CAPACITY];
    logic [spq_pkg::PRIO_W-1:0]     slot_pri [CAPACITY];
    int                             stored;

    result_t               expected_results [$];
    int                    err_count;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    bit                    pressure_go;
    bit                    hold_off;
    int                    cycle_count;

    stable_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock.
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one operation to the predicted queue and returns its output word.
    function automatic result_t queue_step(input spq_pkg::kind_t op,
                                           input logic [spq_pkg::VALUE_W-1:0] val,
                                           input logic [spq_pkg::PRIO_W-1:0] pri);
        result_t r;
        int      pos;
        r.status = spq_pkg::STATUS_OK;
        r.value  = '0;
        r.prio   = '0;
        if (op == spq_pkg::KIND_ENQ)
        begin
            if (stored >= CAPACITY)
            begin
                r.status = spq_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                // Go behind every entry of lower or equal priority number.
                pos = 0;
                while (pos < stored && slot_pri[pos] <= pri)
                    pos++;
                for (int i = stored; i > pos; i--)
                begin
                    slot_val[i] = slot_val[i - 1];
                    slot_pri[i] = slot_pri[i - 1];
                end
                slot_val[pos] = val;
                slot_pri[pos] = pri;
                stored++;
            end
        end
        else
        begin
            if (stored == 0)
            begin
                r.status = spq_pkg::STATUS_UNDERFLOW;
            end
            else
            begin
                r.value = slot_val[0];
                r.prio  = slot_pri[0];
                for (int i = 1; i < stored; i++)
                begin
                    slot_val[i - 1] = slot_val[i];
                    slot_pri[i - 1] = slot_pri[i];
                end
                stored--;
            end
        end
        r.occ = spq_pkg::OCC_W'(stored);
        return r;
    endfunction

    // Offers one word after a random idle gap and returns at the edge
    // where it is accepted.
    task automatic send_word(input spq_pkg::kind_t op,
                             input logic [spq_pkg::VALUE_W-1:0] val,
                             input logic [spq_pkg::PRIO_W-1:0] pri);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= spq_pkg::S_DATA_W'({$urandom, $urandom});
            s_tuser  <= 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pri, val};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        err_count++;
    endtask

    // Output side: random stalls, plus the long hold-off when it is active.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long hold-off, counted here, while the input side keeps offering words.
    initial
    begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // Compare each output word with the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t ns: unexpected output word, expected none, got %h / %h",
                         $time, m_tuser, m_tdata);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("out_value", want.value, m_tdata[31:0]);
                if (m_tdata[39:32] !== want.prio)
                    report_mismatch("out_priority", 32'(want.prio), 32'(m_tdata[39:32]));
                if (m_tdata[44:40] !== want.occ)
                    report_mismatch("occupancy", 32'(want.occ), 32'(m_tdata[44:40]));
            end
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** stable_priority_queue: FAILED **");
        $finish;
    end

    // Stimulus.
    initial
    begin
        result_t                     pred;
        spq_pkg::kind_t              op;
        logic [spq_pkg::VALUE_W-1:0] val;
        logic [spq_pkg::PRIO_W-1:0]  pri;
        int                          enq_pct;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        stored         = 0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b0;
        enq_pct        = 50;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
            begin
                val = DIRECTED[r].val + spq_pkg::VALUE_W'(k);
                send_word(DIRECTED[r].op, val, DIRECTED[r].pri);
                pred = queue_step(DIRECTED[r].op, val, DIRECTED[r].pri);
                if (DIRECTED[r].typed)
                begin
                    pred.status = DIRECTED[r].exp_status;
                    pred.value  = DIRECTED[r].exp_value;
                    pred.prio   = DIRECTED[r].exp_prio;
                    pred.occ    = DIRECTED[r].exp_occ;
                end
                expected_results.push_back(pred);
            end
        end

        // Random words, one idling pattern per phase.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    pressure_go    = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // Tilt the mix now and then so the queue fills and empties.
                if (n % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0:       enq_pct = 20;
                        1:       enq_pct = 50;
                        default: enq_pct = 80;
                    endcase
                end
                op  = ($urandom_range(99) < enq_pct) ? spq_pkg::KIND_ENQ : spq_pkg::KIND_DEQ;
                val = $urandom;
                // Mostly a few priorities so that ties are common.
                if ($urandom_range(2) == 0)
                    pri = spq_pkg::PRIO_W'($urandom);
                else
                    pri = spq_pkg::PRIO_W'($urandom_range(3));
                send_word(op, val, pri);
                expected_results.push_back(queue_step(op, val, pri));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("** stable_priority_queue: PASSED **");
        else
            $display("** stable_priority_queue: FAILED **");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_queue.sv
src/spq_checker.sv
tb/stable_priority_queue_tb.sv
